FILE: hdl/lpg_pkg.sv
`default_nettype none

package lpg_pkg;

    // Coordinate width is fixed by the request and result formats.
    localparam int COORD_BITS = 16;
    localparam int DX_BITS    = COORD_BITS + 1;   // |dx| magnitude
    localparam int NDY_BITS   = COORD_BITS + 2;   // -|dy|, signed
    localparam int ERR_BITS   = COORD_BITS + 3;   // error term, signed
    localparam int E2_BITS    = ERR_BITS + 1;     // doubled error term

    localparam int LPG_CMD_DEPTH = 2;
    localparam int LPG_RES_DEPTH = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [DX_BITS-1:0]    dx_t;
    typedef logic signed [NDY_BITS-1:0]   ndy_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic signed [E2_BITS-1:0]    e2_t;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t  kind;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } request_t;

    typedef struct packed {
        logic   point_valid;
        coord_t point_x;
        coord_t point_y;
        logic   point_last;
    } result_t;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic   load;
        coord_t cur_x;
        coord_t cur_y;
        coord_t target_x;
        coord_t target_y;
        dx_t    delta_x;
        ndy_t   neg_delta_y;
        logic   step_x_neg;
        logic   step_y_neg;
        err_t   error_term;
        logic   last;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/lpg_fifo.sv
`default_nettype none

module lpg_fifo
    import lpg_pkg::*;
#(
    parameter type T     = logic,
    parameter int  DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire T     wr_data,
    output logic      full,
    input  wire logic pop,
    output T          rd_data,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push_ok;
    logic            pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lpg_front.sv
`default_nettype none

module lpg_front
    import lpg_pkg::*;
(
    input  wire request_t request,
    output cmd_t          cmd
);

    logic signed [COORD_BITS:0] dx_raw;
    logic signed [COORD_BITS:0] dy_raw;
    logic signed [COORD_BITS:0] dx_abs;
    logic signed [COORD_BITS:0] dy_abs;
    dx_t                        dx;
    ndy_t                       ndy;

    always_comb
    begin
        // Widen by one bit so the difference cannot wrap.
        dx_raw = {request.end_x[COORD_BITS-1], request.end_x}
               - {request.start_x[COORD_BITS-1], request.start_x};
        dy_raw = {request.end_y[COORD_BITS-1], request.end_y}
               - {request.start_y[COORD_BITS-1], request.start_y};
        dx_abs = dx_raw[COORD_BITS] ? -dx_raw : dx_raw;
        dy_abs = dy_raw[COORD_BITS] ? -dy_raw : dy_raw;
        dx     = dx_t'(dx_abs);
        ndy    = -ndy_t'({1'b0, dy_abs});

        cmd.load        = (request.kind == KIND_LOAD);
        cmd.cur_x       = request.start_x;
        cmd.cur_y       = request.start_y;
        cmd.target_x    = request.end_x;
        cmd.target_y    = request.end_y;
        cmd.delta_x     = dx;
        cmd.neg_delta_y = ndy;
        cmd.step_x_neg  = !(request.start_x < request.end_x);
        cmd.step_y_neg  = !(request.start_y < request.end_y);
        cmd.error_term  = err_t'($signed({1'b0, dx})) + err_t'(ndy);
        cmd.last        = (request.start_x == request.end_x)
                       && (request.start_y == request.end_y);
    end

endmodule

`default_nettype wire

FILE: hdl/lpg_back.sv
`default_nettype none

module lpg_back
    import lpg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic fire,
    input  wire cmd_t cmd,
    output result_t   res
);

    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    coord_t target_x_reg, target_x_next;
    coord_t target_y_reg, target_y_next;
    dx_t    delta_x_reg, delta_x_next;
    ndy_t   neg_delta_y_reg, neg_delta_y_next;
    logic   step_x_neg_reg, step_x_neg_next;
    logic   step_y_neg_reg, step_y_neg_next;
    err_t   error_term_reg, error_term_next;
    logic   finished_reg, finished_next;

    e2_t    e2;
    e2_t    ndy_wide;
    e2_t    dx_wide;
    logic   take_x;
    logic   take_y;
    coord_t step_x;
    coord_t step_y;
    logic   at_end;

    always_comb
    begin
        e2       = {error_term_reg, 1'b0};
        ndy_wide = e2_t'(neg_delta_y_reg);
        dx_wide  = e2_t'($signed({1'b0, delta_x_reg}));
        take_x   = (e2 >= ndy_wide);
        take_y   = (e2 <= dx_wide);
        step_x   = step_x_neg_reg ? cur_x_reg - coord_t'(1) : cur_x_reg + coord_t'(1);
        step_y   = step_y_neg_reg ? cur_y_reg - coord_t'(1) : cur_y_reg + coord_t'(1);

        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        delta_x_next     = delta_x_reg;
        neg_delta_y_next = neg_delta_y_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        error_term_next  = error_term_reg;
        finished_next    = finished_reg;
        at_end           = 1'b0;
        res              = '0;

        if (cmd.load)
        begin
            cur_x_next       = cmd.cur_x;
            cur_y_next       = cmd.cur_y;
            target_x_next    = cmd.target_x;
            target_y_next    = cmd.target_y;
            delta_x_next     = cmd.delta_x;
            neg_delta_y_next = cmd.neg_delta_y;
            step_x_neg_next  = cmd.step_x_neg;
            step_y_neg_next  = cmd.step_y_neg;
            error_term_next  = cmd.error_term;
            finished_next    = cmd.last;
            res.point_valid  = 1'b1;
            res.point_x      = cmd.cur_x;
            res.point_y      = cmd.cur_y;
            res.point_last   = cmd.last;
        end
        else if (!finished_reg)
        begin
            // Both tests use the error term from before this step.
            error_term_next = error_term_reg
                            + (take_x ? err_t'(neg_delta_y_reg) : '0)
                            + (take_y ? err_t'($signed({1'b0, delta_x_reg})) : '0);
            if (take_x)
            begin
                cur_x_next = step_x;
            end
            if (take_y)
            begin
                cur_y_next = step_y;
            end
            at_end          = (cur_x_next == target_x_reg) && (cur_y_next == target_y_reg);
            finished_next   = at_end;
            res.point_valid = 1'b1;
            res.point_x     = cur_x_next;
            res.point_y     = cur_y_next;
            res.point_last  = at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            delta_x_reg     <= '0;
            neg_delta_y_reg <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            error_term_reg  <= '0;
            finished_reg    <= 1'b1;
        end
        else if (fire)
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            delta_x_reg     <= delta_x_next;
            neg_delta_y_reg <= neg_delta_y_next;
            step_x_neg_reg  <= step_x_neg_next;
            step_y_neg_reg  <= step_y_neg_next;
            error_term_reg  <= error_term_next;
            finished_reg    <= finished_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/line_point_generator.sv
`default_nettype none

// Channel   Handshake        Payload     Direction
// request   push / full      request_t   into the block
// result    pop / empty      result_t    out of the block
//
// One request per cycle sustained while the result queue has room; a taken
// request is registered in the request queue, its result in the result queue,
// and only then shows on the ports. The error-term update loop sets the rate.
// Reset clears both queues and marks no line loaded.
// A full result queue stalls the back end; the request queue keeps taking
// requests until it fills, then full rises.

module line_point_generator
    import lpg_pkg::*;
#(
    parameter int CMD_DEPTH = LPG_CMD_DEPTH,
    parameter int RES_DEPTH = LPG_RES_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire request_t request,
    output logic          full,
    input  wire logic     pop,
    output result_t       result,
    output logic          empty
);

    cmd_t    front_cmd;
    cmd_t    back_cmd;
    result_t back_res;
    logic    cmd_empty;
    logic    res_full;
    logic    back_fire;

    // Classify the request and precompute the line setup for loads.
    lpg_front u_front
    (
        .request (request),
        .cmd     (front_cmd)
    );

    // Decouple the front from the stepping back end.
    lpg_fifo #(
        .T     (cmd_t),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_cmd),
        .full    (full),
        .pop     (back_fire),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    // Advance the back end only when a command waits and the result has room.
    assign back_fire = !cmd_empty && !res_full;

    lpg_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (back_fire),
        .cmd   (back_cmd),
        .res   (back_res)
    );

    // Hold results until the consumer pops them.
    lpg_fifo #(
        .T     (result_t),
        .DEPTH (RES_DEPTH)
    ) u_res_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (back_fire),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

`ifndef ASSERT_OFF
    a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.point_valid || !result.point_last))
        else $error("last flag set on a result without a point");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.point_valid) |->
            (result.point_x == '0) && (result.point_y == '0))
        else $error("result without a point carries coordinates");

    a_taken_request_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !cmd_empty)
        else $error("accepted request missing from the request queue");

    a_fire_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        back_fire |=> !empty)
        else $error("back end step produced no queued result");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench;
    import lpg_pkg::*;

    // Tracks the line walk of the block and holds the points it should return.
    class point_scoreboard;
        coord_t  cur_x;
        coord_t  cur_y;
        coord_t  tgt_x;
        coord_t  tgt_y;
        dx_t     dist_x;
        ndy_t    neg_dist_y;
        logic    back_x;
        logic    back_y;
        err_t    err;
        logic    done;
        result_t expected_points[$];
        int      mismatches;

        function new();
            cur_x      = '0;
            cur_y      = '0;
            tgt_x      = '0;
            tgt_y      = '0;
            dist_x     = '0;
            neg_dist_y = '0;
            back_x     = 1'b0;
            back_y     = 1'b0;
            err        = '0;
            done       = 1'b1;
            mismatches = 0;
        endfunction

        // Absolute distance between two coordinates, in plain integers.
        function int span(coord_t a, coord_t b);
            int d;
            d = int'(b) - int'(a);
            return (d < 0) ? -d : d;
        endfunction

        // Advance the walk by one accepted request and queue the point it yields.
        function void note_request(request_t r);
            result_t p;
            int      e2;
            p = '0;
            if (r.kind == KIND_LOAD) begin
                cur_x      = r.start_x;
                cur_y      = r.start_y;
                tgt_x      = r.end_x;
                tgt_y      = r.end_y;
                dist_x     = dx_t'(span(r.start_x, r.end_x));
                neg_dist_y = ndy_t'(-span(r.start_y, r.end_y));
                back_x     = !(r.start_x < r.end_x);
                back_y     = !(r.start_y < r.end_y);
                err        = err_t'(int'(dist_x) + int'(neg_dist_y));
                done       = (cur_x == tgt_x) && (cur_y == tgt_y);
                p.point_valid = 1'b1;
                p.point_x     = cur_x;
                p.point_y     = cur_y;
                p.point_last  = done;
            end
            else if (!done) begin
                // Both decisions use the doubled error term taken up front.
                e2 = 2 * int'(err);
                if (e2 >= int'(neg_dist_y)) begin
                    err   = err_t'(int'(err) + int'(neg_dist_y));
                    cur_x = back_x ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
                end
                if (e2 <= int'(dist_x)) begin
                    err   = err_t'(int'(err) + int'(dist_x));
                    cur_y = back_y ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
                end
                done = (cur_x == tgt_x) && (cur_y == tgt_y);
                p.point_valid = 1'b1;
                p.point_x     = cur_x;
                p.point_y     = cur_y;
                p.point_last  = done;
            end
            expected_points.push_back(p);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_points.size() == 0) begin
                report_mismatch("result with nothing pending, point_x", int'(got.point_x), 0);
                return;
            end
            want = expected_points.pop_front();
            if (got.point_valid !== want.point_valid)
                report_mismatch("point_valid", int'(got.point_valid), int'(want.point_valid));
            if (got.point_x !== want.point_x)
                report_mismatch("point_x", int'(got.point_x), int'(want.point_x));
            if (got.point_y !== want.point_y)
                report_mismatch("point_y", int'(got.point_y), int'(want.point_y));
            if (got.point_last !== want.point_last)
                report_mismatch("point_last", int'(got.point_last), int'(want.point_last));
        endtask

        function int pending();
            return expected_points.size();
        endfunction

        function bit line_done();
            return done;
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     push;
    request_t request;
    logic     full;
    logic     pop;
    result_t  result;
    logic     empty;

    point_scoreboard sb;
    bit              calm;      // set during the stretch with no idling on either side
    int              sent;      // requests accepted so far

    line_point_generator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .request (request),
        .full    (full),
        .pop     (pop),
        .result  (result),
        .empty   (empty)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Roll for an idle cycle; never idle inside the calm stretch.
    function bit roll_idle();
        return !calm && ($urandom_range(99) < 38);
    endfunction

    // Pick a coordinate anywhere, pulled toward the range ends now and then.
    function coord_t pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return coord_t'(-32768 + $urandom_range(15));
        if (r < 20)
            return coord_t'(32767 - $urandom_range(15));
        return coord_t'($urandom);
    endfunction

    // Offset a coordinate by up to reach, clamped to the signed range.
    function coord_t offset_coord(coord_t base, int reach);
        int v;
        v = int'(base) + $urandom_range(2 * reach) - reach;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return coord_t'(v);
    endfunction

    function request_t make_load(int sx, int sy, int ex, int ey);
        request_t r;
        r.kind    = KIND_LOAD;
        r.start_x = coord_t'(sx);
        r.start_y = coord_t'(sy);
        r.end_x   = coord_t'(ex);
        r.end_y   = coord_t'(ey);
        return r;
    endfunction

    // Advance requests carry junk coordinates; the block must ignore them.
    function request_t make_advance();
        request_t r;
        r.kind    = KIND_ADVANCE;
        r.start_x = coord_t'($urandom);
        r.start_y = coord_t'($urandom);
        r.end_x   = coord_t'($urandom);
        r.end_y   = coord_t'($urandom);
        return r;
    endfunction

    function request_t make_random_line();
        request_t r;
        int       reach;
        reach     = ($urandom_range(99) < 5) ? 300 : 12;
        r.kind    = KIND_LOAD;
        r.start_x = pick_coord();
        r.start_y = pick_coord();
        r.end_x   = offset_coord(r.start_x, reach);
        r.end_y   = offset_coord(r.start_y, reach);
        return r;
    endfunction

    // Offer one request, holding it until the block takes it.
    task send_request(request_t r);
        while (roll_idle()) begin
            @(negedge clk);
            push    <= 1'b0;
            request <= make_advance();
        end
        @(negedge clk);
        push    <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (full);
        sb.note_request(r);
        sent++;
    endtask

    // Load a line, then advance until it ends or max_adv advances went out.
    task walk_line(request_t load, int max_adv);
        int n;
        n = 0;
        send_request(load);
        while (!sb.line_done() && n < max_adv) begin
            send_request(make_advance());
            n++;
        end
    endtask

    // Drop push and hold off until every pending point has come back.
    task hold_until_drained();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Result side: roll pop at each falling edge, check at the rising edge.
    initial begin
        pop <= 1'b0;
        forever begin
            @(negedge clk);
            pop <= !roll_idle();
        end
    end

    always @(posedge clk) begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
    end

    initial begin
        int  pick;
        int  extra;
        bit  paused;
        sb      = new();
        calm    = 1'b0;
        sent    = 0;
        paused  = 1'b0;
        rst_n   = 1'b0;
        push    = 1'b0;
        request = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part.
        // Advance with no line loaded must return an empty point.
        send_request(make_advance());
        // Degenerate line at the range corner: start point flagged last at once.
        send_request(make_load(-32768, 32767, -32768, 32767));
        send_request(make_advance());
        // Full-range lines in three directions, one step each, then reload.
        walk_line(make_load(-32768, -32768, 32767, 32767), 1);
        walk_line(make_load(32767, 32767, -32768, -32768), 1);
        walk_line(make_load(32767, -32768, -32768, 32767), 1);
        // Short lines walked to the end: horizontal, vertical, diagonal, steep.
        walk_line(make_load(0, 0, 2, 0), 10);
        walk_line(make_load(0, 0, 0, -2), 10);
        walk_line(make_load(1, 1, -1, -1), 10);
        walk_line(make_load(0, 0, 1, 3), 10);
        // Advance past the end of a finished line.
        send_request(make_advance());
        send_request(make_advance());

        // Random part: mostly whole lines, with cut-short lines and noise mixed in.
        while (sent < 1400) begin
            calm = (sent >= 700 && sent < 850);
            if (!paused && sent >= 450) begin
                hold_until_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 80) begin
                walk_line(make_random_line(), 1000);
                extra = $urandom_range(2);
                repeat (extra) send_request(make_advance());
            end
            else if (pick < 90) begin
                walk_line(make_random_line(), $urandom_range(4));
            end
            else begin
                request_t r;
                r = make_advance();
                r.kind = kind_t'($urandom_range(1));
                send_request(r);
            end
        end
        calm = 1'b0;

        // Wait out the pipeline; any late point counts against the block.
        hold_until_drained();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
